// ===== hw/rtl/smpq_pkg.sv =====
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants for the sorted min-priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned ValW     = 32;
  localparam int unsigned StatW    = 2;
  localparam int unsigned OutCntW  = 7;

  localparam logic ReqPush = 1'b0;
  localparam logic ReqPop  = 1'b1;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                   push;
    logic                   pop;
    logic signed [ValW-1:0] value;
  } smpq_cmd_t;

endpackage

// ===== hw/rtl/smpq_if.sv =====
// ----------------------------------------------------------------------------
// smpq_req_if / smpq_rsp_if
// Valid/ready channels carrying queue requests and results.
// ----------------------------------------------------------------------------
interface smpq_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface smpq_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pop_value;
  logic [1:0]         status;
  logic [6:0]         entry_count;

  modport source (output valid, output pop_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input entry_count,
                  output ready);
endinterface

// ===== hw/rtl/smpq_cell.sv =====
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted chain: holds an entry, shifts right on insert,
// shifts left on pop.
// ----------------------------------------------------------------------------
module smpq_cell (
  input  logic                           clk_i,
  input  smpq_pkg::smpq_cmd_t            cmd_i,
  input  logic                           occ_i,
  input  logic signed [smpq_pkg::ValW-1:0] left_entry_i,
  input  logic                           left_lt_i,
  input  logic signed [smpq_pkg::ValW-1:0] right_entry_i,
  output logic signed [smpq_pkg::ValW-1:0] entry_o,
  output logic                           lt_o
);
  import smpq_pkg::*;

  logic signed [ValW-1:0] entry_q, entry_d;

  // entry stays in place when it is strictly smaller than the new value
  assign lt_o    = occ_i && (entry_q < cmd_i.value);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.push) begin
      if (!lt_o) begin
        entry_d = left_lt_i ? cmd_i.value : left_entry_i;
      end
    end else if (cmd_i.pop) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== hw/rtl/sorted_min_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_top
// Bounded min-priority queue kept sorted ascending in a chain of cells.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                 | handshake
//  req_i   | in  | req_type, push_value                    | valid/ready
//  rsp_o   | out | pop_value, status, entry_count          | valid/ready
//
//  one item per cycle while rsp_o is not stalled: every cell compares
//  against the request in parallel and loads from a neighbor at once
//  the result sits in an output register; req_i.ready is high while that
//  register is empty or being taken, so back-to-back items flow at full rate
//  reset clears the count and the result valid; cell contents are not reset
//  a stalled rsp_o holds the result and stops req_i until it is taken
// ----------------------------------------------------------------------------
module sorted_min_priority_queue_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  smpq_req_if.sink         req_i,
  smpq_rsp_if.source       rsp_o
);
  import smpq_pkg::*;

  // occupancy and handshake
  logic [CntW-1:0] count_q, count_d;
  logic            accept;
  logic            is_pop;
  logic            empty, full;
  smpq_cmd_t       cmd;

  // result register
  logic                   rsp_valid_q, rsp_valid_d;
  logic signed [ValW-1:0] pop_value_q, pop_value_d;
  status_e                status_q, status_d;

  // chain wires
  logic signed [ValW-1:0] entry [Capacity];
  logic                   lt    [Capacity];
  logic                   occ   [Capacity];

  assign empty  = (count_q == '0);
  assign full   = (count_q == CntW'(Capacity));
  assign is_pop = (req_i.req_type == ReqPop);

  // take a new item whenever the result slot is free or draining
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // only successful operations move the chain
  assign cmd.push  = accept && !is_pop && !full;
  assign cmd.pop   = accept && is_pop && !empty;
  assign cmd.value = req_i.push_value;

  // row of cells: cell 0 is the front (smallest entry)
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic signed [ValW-1:0] left_entry, right_entry;
    logic                   left_lt;

    assign occ[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_first
      // nothing in front: a non-smaller front entry takes the new value
      assign left_entry = '0;
      assign left_lt    = 1'b1;
    end else begin : g_mid
      assign left_entry = entry[i-1];
      assign left_lt    = lt[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign right_entry = entry[i];
    end else begin : g_body
      assign right_entry = entry[i+1];
    end

    smpq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occ_i        (occ[i]),
      .left_entry_i (left_entry),
      .left_lt_i    (left_lt),
      .right_entry_i(right_entry),
      .entry_o      (entry[i]),
      .lt_o         (lt[i])
    );
  end

  // next count and result
  always_comb begin
    count_d     = count_q;
    rsp_valid_d = rsp_valid_q;
    pop_value_d = pop_value_q;
    status_d    = status_q;
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (accept) begin
      rsp_valid_d = 1'b1;
      pop_value_d = '0;
      status_d    = ST_OK;
      if (is_pop) begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          pop_value_d = entry[0];
          count_d     = count_q - CntW'(1);
        end
      end else begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
      status_q    <= status_d;
    end
  end

  // result value needs no reset
  always_ff @(posedge clk_i) begin
    pop_value_q <= pop_value_d;
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.pop_value   = pop_value_q;
  assign rsp_o.status      = status_q;
  // count only changes on accept, which also reloads the result
  assign rsp_o.entry_count = OutCntW'(count_q);

  // checks
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("occupancy above capacity");

  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_pop && !full) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("push did not grow occupancy");

  a_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_pop && empty) |=> (status_q == ST_EMPTY && pop_value_q == '0))
    else $error("pop on empty queue not flagged");

  a_front_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (entry[0] <= entry[1]))
    else $error("front entries out of order");

endmodule

// ===== tb/tb_sorted_min_priority_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_min_priority_queue_top
// Self-checking bench for the sorted min-priority queue: push and pop items
// go in over a valid/ready channel and every result is compared against a
// sorted-list predictor. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_sorted_min_priority_queue_top;
  import smpq_pkg::*;

  localparam int unsigned  ClkHalf     = 4;
  localparam int unsigned  RstCycles   = 10;
  localparam int unsigned  RandItems   = 1650;
  localparam int unsigned  MaxIdle     = 18;
  localparam int unsigned  DrainCycles = 8;
  localparam int unsigned  CycleLimit  = 500000;

  localparam logic signed [ValW-1:0] ValMin = 32'sh8000_0000;
  localparam logic signed [ValW-1:0] ValMax = 32'sh7fff_ffff;

  // one expected result of the queue
  typedef struct packed {
    logic signed [ValW-1:0] pop_value;
    status_e                status;
    logic [OutCntW-1:0]     entry_count;
  } queue_result_t;

  // sorted-list predictor plus the store of pending results
  class queue_scoreboard;
    logic signed [ValW-1:0] held[$];      // ascending, head is the minimum
    queue_result_t          pending[$];
    int unsigned            errors;
    int unsigned            n_push_ok, n_pop_ok, n_full, n_empty, peak;

    function new();
      errors    = 0;
      n_push_ok = 0;
      n_pop_ok  = 0;
      n_full    = 0;
      n_empty   = 0;
      peak      = 0;
    endfunction

    // predict the result of one accepted request
    function void note_request(input logic req_type, input logic signed [ValW-1:0] value);
      queue_result_t res;
      int            pos;
      res.pop_value = '0;
      res.status    = ST_OK;
      if (req_type == ReqPush) begin
        if (held.size() >= Capacity) begin
          res.status = ST_FULL;
          n_full++;
        end else begin
          // insert ahead of the first entry that is not smaller
          pos = 0;
          while (pos < held.size() && held[pos] < value) pos++;
          held.insert(pos, value);
          n_push_ok++;
        end
      end else begin
        if (held.size() == 0) begin
          res.status = ST_EMPTY;
          n_empty++;
        end else begin
          res.pop_value = held.pop_front();
          n_pop_ok++;
        end
      end
      res.entry_count = OutCntW'(held.size());
      if (held.size() > peak) peak = held.size();
      pending.push_back(res);
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(input logic signed [ValW-1:0] pop_value,
                               input logic [StatW-1:0] status,
                               input logic [OutCntW-1:0] entry_count);
      queue_result_t exp_res;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result pop_value %0d status %0d entry_count %0d",
                 $time, pop_value, status, entry_count);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (pop_value !== exp_res.pop_value) begin
        $display("%0t: pop_value mismatch expected %0d actual %0d",
                 $time, exp_res.pop_value, pop_value);
        errors++;
      end
      if (status !== exp_res.status) begin
        $display("%0t: status mismatch expected %0d actual %0d",
                 $time, exp_res.status, status);
        errors++;
      end
      if (entry_count !== exp_res.entry_count) begin
        $display("%0t: entry_count mismatch expected %0d actual %0d",
                 $time, exp_res.entry_count, entry_count);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  bit          no_idle;      // set for stretches where neither side idles
  int unsigned cycle_cnt = 0;
  queue_scoreboard sb;

  smpq_req_if req_if ();
  smpq_rsp_if rsp_if ();

  sorted_min_priority_queue_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // 8 ns clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // value mix: full-range words, a narrow band for duplicates, a +/-1000 band, the extremes
  function automatic logic signed [ValW-1:0] pick_value();
    logic signed [ValW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = $signed($urandom_range(0, 16)) - 8;
      7: begin
        case ($urandom_range(0, 5))
          0:       v = ValMin;
          1:       v = ValMax;
          2:       v = ValMin + 1;
          3:       v = ValMax - 1;
          4:       v = -1;
          default: v = 0;
        endcase
      end
      default:    v = $signed($urandom_range(0, 2000)) - 1000;
    endcase
    return v;
  endfunction

  // drive one request item; valid stays high after acceptance so that a
  // zero gap to the next item needs no second assignment in the same step
  task automatic send_request(input logic req_type, input logic signed [ValW-1:0] value);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MaxIdle);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= req_type;
    req_if.push_value <= value;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_request(req_type, value);
  endtask

  // result side: random stalls, each result checked at its handshake
  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MaxIdle);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      sb.check_result(rsp_if.pop_value, rsp_if.status, rsp_if.entry_count);
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned sent;
    int unsigned seg_len;
    int unsigned push_pct;
    int unsigned k;
    logic        rt;

    sb = new();
    no_idle            = 1'b0;
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= ReqPush;
    req_if.push_value <= '0;
    rsp_if.ready      <= 1'b0;
    repeat (RstCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pop, extremes, equal values at head and tail, drain
    send_request(ReqPop,  '0);
    send_request(ReqPush, ValMax);
    send_request(ReqPush, ValMin);
    send_request(ReqPush, 0);
    send_request(ReqPush, -1);
    send_request(ReqPush, 1);
    send_request(ReqPush, 0);        // equal to a middle entry
    send_request(ReqPush, ValMin);   // equal to the head
    send_request(ReqPush, ValMax);   // equal to the tail
    send_request(ReqPop,  ValMax);   // pop ignores push_value
    send_request(ReqPop,  '0);
    send_request(ReqPush, -5);
    send_request(ReqPush, -5);
    repeat (9) send_request(ReqPop, '1);
    send_request(ReqPop,  '0);       // empty again

    // random: first a fill past capacity and a full drain, then mixed
    // stretches with a bias toward push or pop so both ends are hit often
    sent = 0;
    k    = 0;
    while (sent < RandItems) begin
      case (k)
        0:       begin push_pct = 100; seg_len = Capacity + 6; end
        1:       begin push_pct = 0;   seg_len = Capacity + 6; end
        default: begin
          case ($urandom_range(0, 5))
            0:       push_pct = 95;
            1:       push_pct = 80;
            2:       push_pct = 50;
            3:       push_pct = 20;
            4:       push_pct = 5;
            default: push_pct = 60;
          endcase
          seg_len = $urandom_range(30, 120);
        end
      endcase
      no_idle = ($urandom_range(0, 4) == 0);
      repeat (seg_len) begin
        rt = ($urandom_range(1, 100) <= push_pct) ? ReqPush : ReqPop;
        // pops carry random junk in push_value as well
        send_request(rt, rt == ReqPush ? pick_value() : $urandom);
        sent++;
      end
      k++;
    end
    req_if.valid <= 1'b0;
    no_idle       = 1'b0;

    // every result back, then a quiet drain period to catch strays
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d good pushes, %0d good pops, %0d pushes when full, %0d pops when empty",
             sb.n_push_ok, sb.n_pop_ok, sb.n_full, sb.n_empty);
    $display("peak occupancy %0d of %0d, %0d mismatches", sb.peak, Capacity, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
